### src/i2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_pkg: shared definitions for the integer to decimal text converter
// Widths, character codes and the queue entry passed from front to back end.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int MAG_W          = 64;
  localparam int NUM_DIGITS     = 20;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int STEP_W         = $clog2(MAG_W);
  localparam int REMAIN_W       = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W         = 8;
  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // One converted value waiting to be spelt out.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } i2d_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } i2d_qstat_t;

endpackage

### src/int64_to_decimal_ascii.sv
`timescale 1ns / 1ps
// An accepted value goes through the bit-serial 64-step BCD conversion and the queue
//   to the output side, which writes a minus sign first and drops leading zeros.
// The front end takes a new value only after pushing the last; busy stays high until
//   that push, and so longer while the queue to the output side is full.
// Digits then leave one per cycle; the receiver cannot stall, so output never waits.
// Reset (synchronous, active high) empties the queue and returns both ends to idle.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: signed 64-bit integer to decimal ASCII text
// A converting front end and a character-emitting back end joined by a queue.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii import i2d_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [MAG_W-1:0] value,
  output logic                    busy,
  output logic [CHAR_W-1:0]       text_char,
  output logic                    last_char,
  output logic                    char_valid
);

  logic       push;
  logic       pop;
  i2d_entry_t push_data;
  i2d_entry_t head;
  i2d_qstat_t qstat;

  i2d_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .qstat     (qstat)
  );

  i2d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  i2d_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .text_char  (text_char),
    .last_char  (last_char),
    .char_valid (char_valid)
  );

endmodule

### src/i2d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_fifo: short queue between conversion and character output
// Flop-based first-in first-out buffer of converted values.
// ----------------------------------------------------------------------------
module i2d_fifo import i2d_pkg::*; #(
  parameter int Depth = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  i2d_entry_t push_data,
  input  logic       pop,
  output i2d_entry_t head,
  output i2d_qstat_t qstat
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  i2d_entry_t            mem [Depth];
  logic [IdxW-1:0]       wr_ptr;
  logic [IdxW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.full  = (count == CntW'(Depth));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue read while empty");
`endif

endmodule

### src/i2d_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_conv: front end, takes a value and converts its magnitude to BCD
// Shift-and-add-three conversion, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module i2d_conv import i2d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [MAG_W-1:0] value,
  output logic                    busy,
  output logic                    push,
  output i2d_entry_t              push_data,
  input  i2d_qstat_t              qstat
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } conv_state_t;

  conv_state_t        state;
  logic [MAG_W-1:0]   bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [STEP_W-1:0]  step;
  logic               neg;
  logic [MAG_W-1:0]   mag_in;

  // The magnitude is taken as unsigned, so the most negative value is exact.
  assign mag_in = value[MAG_W-1] ? (~$unsigned(value) + MAG_W'(1)) : $unsigned(value);

  always_comb begin
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  assign busy           = (state != F_IDLE);
  assign push           = (state == F_PUSH) && !qstat.full;
  assign push_data.neg  = neg;
  assign push_data.bcd  = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            neg   <= value[MAG_W-1];
            bin   <= mag_in;
            bcd   <= '0;
            step  <= '0;
            state <= F_CONV;
          end
        end
        F_CONV: begin
          bcd  <= {bcd_adj[BCD_W-2:0], bin[MAG_W-1]};
          bin  <= {bin[MAG_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == STEP_W'(MAG_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!qstat.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_conv: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == F_CONV))
    else $error("accepted beat did not start conversion");
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    push |=> (state == F_IDLE))
    else $error("front end did not return to idle after push");
`endif

endmodule

### src/i2d_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2d_emit: back end, spells a converted value out as ASCII characters
// Sign first, leading zeros skipped, then one digit per cycle.
// ----------------------------------------------------------------------------
module i2d_emit import i2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  i2d_qstat_t        qstat,
  input  i2d_entry_t        head,
  output logic              pop,
  output logic [CHAR_W-1:0] text_char,
  output logic              last_char,
  output logic              char_valid
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SIGN = 4'b0010,
    B_SKIP = 4'b0100,
    B_EMIT = 4'b1000
  } emit_state_t;

  emit_state_t          state;
  logic [BCD_W-1:0]     bcd;
  logic [REMAIN_W-1:0]  remain;
  logic [DIGIT_W-1:0]   top;
  logic                 final_digit;

  assign pop         = (state == B_IDLE) && !qstat.empty;
  assign top         = bcd[BCD_W-1 -: DIGIT_W];
  assign final_digit = (remain == REMAIN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      char_valid <= 1'b0;
    end else begin
      char_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            bcd    <= head.bcd;
            remain <= REMAIN_W'(NUM_DIGITS);
            state  <= head.neg ? B_SIGN : B_SKIP;
          end
        end
        B_SIGN: begin
          char_valid <= 1'b1;
          text_char  <= ASCII_MINUS;
          last_char  <= 1'b0;
          state      <= B_SKIP;
        end
        B_SKIP, B_EMIT: begin
          // Leading zeros are dropped, but the units digit is always spelt.
          if ((state == B_SKIP) && (top == '0) && !final_digit) begin
            bcd    <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            remain <= remain - 1'b1;
          end else begin
            char_valid <= 1'b1;
            text_char  <= ASCII_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top};
            last_char  <= final_digit;
            bcd        <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            remain     <= remain - 1'b1;
            state      <= final_digit ? B_IDLE : B_EMIT;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && (text_char == ASCII_MINUS)) |-> !last_char)
    else $error("minus sign flagged as final character");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for int64_to_decimal_ascii
// Sends signed 64-bit values through the start/busy handshake and checks the
// stream of decimal characters against a value-by-value text predictor.
// ----------------------------------------------------------------------------
module testbench;
  import i2d_pkg::*;

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic                    clk;
  logic                    rst   = 1'b1;
  logic                    start = 1'b0;
  logic signed [MAG_W-1:0] value = '0;
  logic                    busy;
  logic [CHAR_W-1:0]       text_char;
  logic                    last_char;
  logic                    char_valid;

  char_beat_t expected_chars[$];
  char_beat_t oldest_char;
  int         mismatches    = 0;
  int         values_sent   = 0;
  int         negatives     = 0;
  int         chars_checked = 0;
  bit         sender_idles  = 1'b1;

  int64_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .text_char (text_char),
    .last_char (last_char),
    .char_valid(char_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queues the characters that the decimal text of one value should produce.
  function automatic void predict_text(input logic signed [MAG_W-1:0] v);
    logic [MAG_W-1:0]   magnitude;
    logic [DIGIT_W-1:0] digit_buf [NUM_DIGITS];
    int                 n_digits;
    char_beat_t         beat;
    // Forming the magnitude in unsigned arithmetic keeps the most negative
    // value intact.
    magnitude = v[MAG_W-1] ? (~$unsigned(v) + 64'd1) : $unsigned(v);
    for (n_digits = 0; n_digits == 0 || magnitude != 0; n_digits++) begin
      digit_buf[n_digits] = DIGIT_W'(magnitude % RADIX);
      magnitude           = magnitude / RADIX;
    end
    if (v[MAG_W-1]) begin
      beat.ch   = ASCII_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      beat.ch   = ASCII_ZERO + CHAR_W'(digit_buf[i]);
      beat.last = (i == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  // Presents one value and returns once the block has taken the beat. Start is
  // left high unless an idle burst follows, so a following beat never lowers
  // and raises it in the same time step.
  task automatic send_value(input logic signed [MAG_W-1:0] v);
    int gap;
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_text(v);
    values_sent++;
    if (v < 0) negatives++;
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_text_drained();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [MAG_W-1:0] random_value();
    logic [MAG_W-1:0] raw;
    logic [MAG_W-1:0] pow;
    int               k;
    raw = {$urandom, $urandom};
    pow = 64'd1;
    case ($urandom_range(0, 3))
      0: return raw;
      1: return raw >> $urandom_range(1, 63);
      2: return -$signed(raw >> $urandom_range(1, 63));
      default: begin
        // Values just either side of a power of ten change the digit count.
        k = $urandom_range(0, 18);
        repeat (k) pow = pow * RADIX;
        pow = pow + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? -$signed(pow) : $signed(pow);
      end
    endcase
  endfunction

  task automatic test_small_values();
    send_value(64'sd0);
    send_value(64'sd1);
    send_value(-64'sd1);
    send_value(64'sd9);
    send_value(-64'sd9);
    send_value(64'sd10);
    send_value(-64'sd10);
    send_value(64'sd99);
    send_value(64'sd100);
    send_value(-64'sd100);
  endtask

  task automatic test_extremes();
    send_value(64'sh7FFF_FFFF_FFFF_FFFF);
    send_value(64'sh8000_0000_0000_0000);
    send_value(64'sh8000_0000_0000_0001);
  endtask

  task automatic test_digit_boundaries();
    send_value(64'sd999999999999999999);
    send_value(64'sd1000000000000000000);
    send_value(-64'sd999999999999999999);
    send_value(-64'sd1000000000000000000);
  endtask

  task automatic test_bit_patterns();
    send_value(64'sh5555_5555_5555_5555);
    send_value(64'shAAAA_AAAA_AAAA_AAAA);
    send_value(64'sh0123_4567_89AB_CDEF);
    send_value(64'shFEDC_BA98_7654_3210);
  endtask

  task automatic test_random_with_idling(input int count);
    for (int n = 0; n < count; n++) begin
      send_value(random_value());
      if ($urandom_range(0, 49) == 0) wait_for_text_drained();
    end
  endtask

  task automatic test_back_to_back(input int count);
    sender_idles = 1'b0;
    for (int n = 0; n < count; n++) send_value(random_value());
    start <= 1'b0;
  endtask

  // Each character is on the outputs for one cycle only, so every strobe is
  // taken at the edge that closes it.
  always @(posedge clk) begin
    if (!rst && char_valid) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character, expected none, actual %h last %0b",
                 $time, text_char, last_char);
      end else begin
        oldest_char = expected_chars.pop_front();
        chars_checked++;
        if (text_char !== oldest_char.ch) begin
          mismatches++;
          $display("%0t: text_char mismatch, expected %h, actual %h",
                   $time, oldest_char.ch, text_char);
        end
        if (last_char !== oldest_char.last) begin
          mismatches++;
          $display("%0t: last_char mismatch, expected %0b, actual %0b",
                   $time, oldest_char.last, last_char);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_small_values();
    test_extremes();
    test_digit_boundaries();
    test_bit_patterns();
    wait_for_text_drained();
    test_random_with_idling(300);
    wait_for_text_drained();
    test_back_to_back(140);
    wait_for_text_drained();
    repeat (100) @(posedge clk);
    $display("Formatted %0d values (%0d negative) into %0d checked characters,",
             values_sent, negatives, chars_checked);
    $display("including both 64-bit extremes, zero and every digit count.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
